// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the scaler RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/yrs_pkg.sv
// ----------------------------------------------------------------------------
// yrs_pkg
// Shared constants, codes and types of the YUYV/RGB565 scaler.
// ----------------------------------------------------------------------------
package yrs_pkg;

	localparam int MAX_LINE_PAIRS_DEF = 512;

	localparam int WORD_W   = 32;
	localparam int PIX_W    = 16;
	localparam int PPL_W    = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [PPL_W-1:0] PPL_RESET = PPL_W'(160);

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAIRS_PER_LINE = 2'd2;

	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_UP   = 2'd1;
	localparam logic [1:0] MODE_DOWN = 2'd2;

	localparam logic FMT_YUYV   = 1'b0;
	localparam logic FMT_RGB565 = 1'b1;

	localparam logic OP_NEW    = 1'b0;
	localparam logic OP_REPLAY = 1'b1;

	// result pattern of one item
	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_PAIR   = 2'd1;
	localparam logic [1:0] KIND_DOUBLE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       eol;
	} item_ctrl_t;

endpackage

// File: src/yrs_lane.sv
// ----------------------------------------------------------------------------
// yrs_lane
// One pixel lane: BT.601 YUV to RGB565 over two stages, or RGB565 pass.
// ----------------------------------------------------------------------------
module yrs_lane (
	input  logic                      clk,
	input  logic                      en_s2,
	input  logic                      en_s3,
	input  logic                      fmt,
	input  logic [7:0]                y,
	input  logic [7:0]                u,
	input  logic [7:0]                v,
	input  logic [yrs_pkg::PIX_W-1:0] raw,
	output logic [yrs_pkg::PIX_W-1:0] pixel
);
	import yrs_pkg::*;

	localparam int ACC_W = 20;

	logic signed [9:0]       c, d, e;
	logic signed [ACC_W-1:0] c_x, d_x, e_x;
	logic signed [ACC_W-1:0] m_yc_s2, m_re_s2, m_gd_s2, m_ge_s2, m_bd_s2;
	logic [PIX_W-1:0]        raw_s2;
	logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;
	logic [7:0]              r8, g8, b8;
	logic [PIX_W-1:0]        pixel_s3;

	function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
		logic [7:0] res;
		if (acc < 0) begin
			res = 8'd0;
		end else if (acc[ACC_W-1:16] != '0) begin
			res = 8'hFF;
		end else begin
			res = acc[15:8];
		end
		return res;
	endfunction

	assign c = $signed({2'b00, y}) - 10'sd16;
	assign d = $signed({2'b00, u}) - 10'sd128;
	assign e = $signed({2'b00, v}) - 10'sd128;
	assign c_x = ACC_W'(c);
	assign d_x = ACC_W'(d);
	assign e_x = ACC_W'(e);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			m_yc_s2 <= c_x * 20'sd298;
			m_re_s2 <= e_x * 20'sd409;
			m_gd_s2 <= d_x * 20'sd100;
			m_ge_s2 <= e_x * 20'sd208;
			m_bd_s2 <= d_x * 20'sd516;
			raw_s2  <= raw;
		end
	end

	assign acc_r = m_yc_s2 + m_re_s2 + 20'sd128;
	assign acc_g = m_yc_s2 - m_gd_s2 - m_ge_s2 + 20'sd128;
	assign acc_b = m_yc_s2 + m_bd_s2 + 20'sd128;
	assign r8 = clamp_channel(acc_r);
	assign g8 = clamp_channel(acc_g);
	assign b8 = clamp_channel(acc_b);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pixel_s3 <= (fmt == FMT_RGB565) ? raw_s2 : {r8[7:3], g8[7:2], b8[7:3]};
		end
	end

	assign pixel = pixel_s3;

endmodule

// File: src/yrs_merge.sv
// ----------------------------------------------------------------------------
// yrs_merge
// Output stage: merges the two lane pixels into the result sequence.
// ----------------------------------------------------------------------------
module yrs_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  yrs_pkg::item_ctrl_t       in_ctrl,
	input  logic [yrs_pkg::PIX_W-1:0] in_p0,
	input  logic [yrs_pkg::PIX_W-1:0] in_p1,
	output logic                      take,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [yrs_pkg::PIX_W-1:0] pixel,
	output logic                      last_of_item,
	output logic                      row_end
);
	import yrs_pkg::*;

	logic             busy_q;
	logic [1:0]       idx_q;
	item_ctrl_t       ctrl_q;
	logic [PIX_W-1:0] p0_q, p1_q;
	logic             last;
	logic             done;

	always_comb begin
		case (ctrl_q.kind)
			KIND_DOUBLE: begin
				last  = (idx_q == 2'd3);
				pixel = idx_q[1] ? p1_q : p0_q;
			end
			KIND_PAIR: begin
				last  = (idx_q == 2'd1);
				pixel = idx_q[0] ? p1_q : p0_q;
			end
			default: begin
				last  = 1'b1;
				pixel = p0_q;
			end
		endcase
	end

	assign done         = busy_q && !out_stall && last;
	assign take         = in_valid && (!busy_q || done);
	assign out_valid    = busy_q;
	assign last_of_item = last;
	assign row_end      = last && ctrl_q.eol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (busy_q && !out_stall) begin
			busy_q <= !last;
			idx_q  <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_q <= in_ctrl;
			p0_q   <= in_p0;
			p1_q   <= in_p1;
		end
	end

endmodule

// File: src/yuyv_to_rgb565_scaler.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_scaler
// YUYV/RGB565 word stream to RGB565 pixels with 2x nearest scaling.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one source word. Two conversion lanes
// decode its two pixels side by side in a two-stage BT.601 pipeline and an
// output serialiser emits one result per cycle while out_stall is low; an
// item has 4 results in upscale, 2 with no scaling, 1 in downscale. Items
// with no result (odd downscale rows, replays outside upscale) are accepted
// but enter no pipeline stage. Results pass stage 1, the lane stages 2 and 3
// and the merge register. The line store needs no clearing pass: a replay
// must only read entries written during the preceding line.
module yuyv_to_rgb565_scaler #(
	parameter int MAX_LINE_PAIRS = yrs_pkg::MAX_LINE_PAIRS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [yrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yrs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [yrs_pkg::WORD_W-1:0]     src_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [yrs_pkg::PIX_W-1:0]      pixel,
	output logic                           last_of_item,
	output logic                           row_end
);
	import yrs_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
	localparam int LW = (AW + 1 > PPL_W) ? AW + 1 : PPL_W;
	localparam logic [LW-1:0] MAX_L = LW'(MAX_LINE_PAIRS);

	logic             fmt_q;
	logic [1:0]       scale_q;
	logic [PPL_W-1:0] ppl_q;
	logic [AW-1:0]    col_q, rep_q;
	logic             odd_q;

	logic [WORD_W-1:0] store_q [MAX_LINE_PAIRS];
	logic [WORD_W-1:0] rd_q;

	logic [LW-1:0] ppl_ext, len;
	logic          mode_up, mode_down, is_replay, emit;
	logic          eol_new, eol_rep;
	logic          accept, wr_en, rd_en;
	item_ctrl_t    ctrl_in;

	logic              v_s1, v_s2, v_s3;
	logic              ready1, ready2, ready3, adv1, adv2, adv3;
	logic [WORD_W-1:0] word_s1, lane_word;
	logic              replay_s1;
	item_ctrl_t        ctrl_s1, ctrl_s2, ctrl_s3;
	logic [PIX_W-1:0]  lane_p0, lane_p1;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_YUYV;
			scale_q <= MODE_NONE;
			ppl_q   <= PPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_INPUT_FORMAT:   fmt_q   <= cfg_data[0];
				REG_SCALE_MODE:     scale_q <= cfg_data[1:0];
				REG_PAIRS_PER_LINE: ppl_q   <= cfg_data[PPL_W-1:0];
				default: ;
			endcase
		end
	end

	// line length and item decode
	assign ppl_ext = LW'(ppl_q);
	always_comb begin
		if (ppl_ext == '0) begin
			len = LW'(1);
		end else if (ppl_ext > MAX_L) begin
			len = MAX_L;
		end else begin
			len = ppl_ext;
		end
	end

	assign mode_up   = (scale_q == MODE_UP);
	assign mode_down = (scale_q == MODE_DOWN);
	assign is_replay = (opcode == OP_REPLAY);
	assign eol_new   = (LW'(col_q) + LW'(1)) >= len;
	assign eol_rep   = (LW'(rep_q) + LW'(1)) >= len;
	assign emit      = is_replay ? mode_up : !(mode_down && odd_q);

	always_comb begin
		ctrl_in.eol = is_replay ? eol_rep : eol_new;
		if (mode_up) begin
			ctrl_in.kind = KIND_DOUBLE;
		end else if (mode_down) begin
			ctrl_in.kind = KIND_SINGLE;
		end else begin
			ctrl_in.kind = KIND_PAIR;
		end
	end

	// pipeline handshake
	assign ready3   = !v_s3 || adv3;
	assign adv2     = v_s2 && ready3;
	assign ready2   = !v_s2 || adv2;
	assign adv1     = v_s1 && ready2;
	assign ready1   = !v_s1 || adv1;
	assign in_stall = !ready1;
	assign accept   = in_valid && ready1;
	assign wr_en    = accept && !is_replay && mode_up;
	assign rd_en    = accept && is_replay && mode_up;

	// line position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			rep_q <= '0;
			odd_q <= 1'b0;
		end else if (accept) begin
			if (is_replay) begin
				if (mode_up) begin
					rep_q <= eol_rep ? '0 : rep_q + AW'(1);
				end
			end else begin
				col_q <= eol_new ? '0 : col_q + AW'(1);
				odd_q <= odd_q ^ eol_new;
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[col_q] <= src_word;
		end
		if (rd_en) begin
			rd_q <= store_q[rep_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready1) v_s1 <= accept && emit;
			if (ready2) v_s2 <= v_s1;
			if (ready3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1   <= src_word;
			replay_s1 <= is_replay;
			ctrl_s1   <= ctrl_in;
		end
		if (adv1) ctrl_s2 <= ctrl_s1;
		if (adv2) ctrl_s3 <= ctrl_s2;
	end

	assign lane_word = replay_s1 ? rd_q : word_s1;

	yrs_lane u_lane0 (
		.clk   (clk),
		.en_s2 (adv1),
		.en_s3 (adv2),
		.fmt   (fmt_q),
		.y     (lane_word[7:0]),
		.u     (lane_word[15:8]),
		.v     (lane_word[31:24]),
		.raw   (lane_word[15:0]),
		.pixel (lane_p0)
	);

	yrs_lane u_lane1 (
		.clk   (clk),
		.en_s2 (adv1),
		.en_s3 (adv2),
		.fmt   (fmt_q),
		.y     (lane_word[23:16]),
		.u     (lane_word[15:8]),
		.v     (lane_word[31:24]),
		.raw   (lane_word[31:16]),
		.pixel (lane_p1)
	);

	yrs_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (v_s3),
		.in_ctrl      (ctrl_s3),
		.in_p0        (lane_p0),
		.in_p1        (lane_p1),
		.take         (adv3),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel        (pixel),
		.last_of_item (last_of_item),
		.row_end      (row_end)
	);

	`ASSERT_NEXT(a_store_wr_double, clk, arst_n, wr_en, v_s1 && ctrl_s1.kind == KIND_DOUBLE, "store write without upscale item")
	`ASSERT_NEXT(a_s3_hold, clk, arst_n, v_s3 && !adv3, v_s3 && $stable(ctrl_s3), "stage 3 lost its item")
	`ASSERT_PROP(a_empty_accepts, clk, arst_n, v_s1 || !in_stall, "stall with empty first stage")

endmodule
